@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros for the cache tag engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert a property on the rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/sact_pkg.sv @@
// ----------------------------------------------------------------------------
// sact_pkg
// Types and constants shared by the cache tag engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sact_pkg;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [1:0] POL_LRU    = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_SEED   = 1'b1;

  localparam logic [15:0] LFSR_MASK = 16'hB400;

  typedef struct packed {
    logic        operation;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [1:0]  way;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sact_front.sv @@
// ----------------------------------------------------------------------------
// sact_front
// Accepts request beats and holds them in a small queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_front #(
  parameter int DEPTH = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  sact_pkg::req_t       in_data_i,
  output logic                 q_valid_o,
  input  wire                  q_pop_i,
  output sact_pkg::req_t       q_data_o
);
  import sact_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  req_t           mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [PW:0]    cnt_q;
  logic           push;

  assign in_stall_o = (cnt_q == (PW+1)'(DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + PW'(1);
      end
      if (q_pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop_i);
    end
  end
endmodule

`default_nettype wire

@@ hw/rtl/sact_back.sv @@
// ----------------------------------------------------------------------------
// sact_back
// Tag lookup, replacement and counter update over a per-set line memory.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_back #(
  parameter int NUM_SETS    = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  q_valid_i,
  output logic                 q_pop_o,
  input  sact_pkg::req_t       q_data_i,
  input  wire  [1:0]           policy_i,
  input  wire                  seed_wr_i,
  input  wire  [15:0]          seed_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output sact_pkg::rsp_t       out_data_o
);
  import sact_pkg::*;

  localparam int OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int IDX_RAW  = $clog2(NUM_SETS + 1) - 1;
  localparam int IW       = (IDX_RAW > 0) ? IDX_RAW : 1;
  localparam int TAG_BITS = 32 - OFF_BITS - IDX_RAW;
  localparam int TW       = (TAG_BITS > 0) ? TAG_BITS : 1;
  localparam int WW       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SETS     = 1 << IDX_RAW;
  localparam int AM       = (ADDR_BITS < 32) ? ADDR_BITS : 32;

  typedef struct packed {
    logic [WAYS-1:0]         valid;
    logic [WAYS-1:0][TW-1:0] tag;
    logic [WAYS-1:0][WW-1:0] rec;
    logic [WAYS-1:0][WW-1:0] ins;
  } set_t;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  set_t           mem [SETS];
  set_t           rd_q;
  logic [1:0]     st_q;
  logic [IW-1:0]  idx_q;
  logic [TW-1:0]  tag_q;
  logic [31:0]    hits_q, miss_q, evs_q;
  logic [15:0]    lfsr_q, lfsr_nx;
  rsp_t           out_q;
  logic [SETS-1:0] sv_q;

  logic [31:0]     addr;
  logic [IW-1:0]   a_idx;
  logic [TW-1:0]   a_tag;
  set_t            cur, upd;
  logic            hit, free, evict;
  logic [WW-1:0]   way, vict, r_old, i_old;
  logic [WW:0]     rlim, ilim;
  logic            start, mem_we;

  always_comb begin
    addr = q_data_i.address;
    if (AM < 32) addr = addr & ((32'd1 << AM) - 32'd1);
    a_idx = (IDX_RAW > 0) ? IW'(addr >> OFF_BITS) : '0;
    a_tag = TW'(addr >> (OFF_BITS + IDX_RAW));
  end

  assign q_pop_o     = (st_q == ST_IDLE) && q_valid_i;
  assign start       = q_pop_o;
  assign busy_o      = (st_q != ST_IDLE) || q_valid_i;
  assign out_valid_o = (st_q == ST_OUT);
  assign out_data_o  = out_q;

  // A set never written since reset or clear reads as empty.
  always_comb begin
    cur = rd_q;
    if (!sv_q[idx_q]) cur = '0;
  end

  always_comb begin
    hit  = 1'b0;
    free = 1'b0;
    way  = '0;
    vict = '0;
    for (int v = WAYS - 1; v >= 0; v--) begin
      if (cur.valid[v] && cur.tag[v] == tag_q) begin
        hit = 1'b1;
        way = WW'(v);
      end
    end
    for (int v = WAYS - 1; v >= 0; v--) begin
      if (!cur.valid[v]) begin
        free = 1'b1;
        vict = WW'(v);
      end
    end
    lfsr_nx = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : 16'h0);
    if (!free) begin
      vict = '0;
      case (policy_i)
        POL_LRU: begin
          for (int v = 1; v < WAYS; v++)
            if (cur.rec[v] > cur.rec[vict]) vict = WW'(v);
        end
        POL_FIFO: begin
          for (int v = 1; v < WAYS; v++)
            if (cur.ins[v] > cur.ins[vict]) vict = WW'(v);
        end
        POL_RANDOM: vict = WW'(lfsr_nx % WAYS);
        default:    vict = '0;
      endcase
    end
    evict = !hit && !free;
    if (!hit) way = vict;
    r_old = cur.rec[way];
    i_old = cur.ins[way];
    rlim  = (hit || evict) ? {1'b0, r_old} : (WW+1)'(WAYS);
    ilim  = evict ? {1'b0, i_old} : (WW+1)'(WAYS);
    upd   = cur;
    for (int v = 0; v < WAYS; v++) begin
      if (WW'(v) != way && cur.valid[v]) begin
        if ({1'b0, cur.rec[v]} < rlim) upd.rec[v] = cur.rec[v] + WW'(1);
        if (!hit && {1'b0, cur.ins[v]} < ilim) upd.ins[v] = cur.ins[v] + WW'(1);
      end
    end
    upd.rec[way] = '0;
    if (!hit) begin
      upd.ins[way]   = '0;
      upd.valid[way] = 1'b1;
      upd.tag[way]   = tag_q;
    end
  end

  assign mem_we = (st_q == ST_READ);

  always_ff @(posedge clk_i) begin
    if (start) begin
      rd_q  <= mem[a_idx];
      idx_q <= a_idx;
      tag_q <= a_tag;
    end
    if (mem_we) begin
      mem[idx_q] <= upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      hits_q <= '0;
      miss_q <= '0;
      evs_q  <= '0;
      lfsr_q <= 16'd1;
      sv_q   <= '0;
      out_q  <= '0;
    end else begin
      if (seed_wr_i) lfsr_q <= (seed_i == 16'd0) ? 16'd1 : seed_i;
      unique case (st_q)
        ST_IDLE: begin
          if (start) begin
            st_q <= (q_data_i.operation == OP_CLEAR) ? ST_CLEAR : ST_READ;
          end
        end
        ST_READ: begin
          sv_q[idx_q]   <= 1'b1;
          out_q.hit     <= hit;
          out_q.evicted <= evict;
          out_q.way     <= 2'(way);
          if (hit) begin
            hits_q          <= sat_inc(hits_q);
            out_q.hit_count <= sat_inc(hits_q);
          end else begin
            out_q.hit_count <= hits_q;
          end
          out_q.miss_count     <= hit ? miss_q : sat_inc(miss_q);
          out_q.eviction_count <= evict ? sat_inc(evs_q) : evs_q;
          if (!hit) miss_q <= sat_inc(miss_q);
          if (evict) evs_q <= sat_inc(evs_q);
          if (evict && policy_i == POL_RANDOM) lfsr_q <= lfsr_nx;
          st_q <= ST_OUT;
        end
        ST_CLEAR: begin
          sv_q   <= '0;
          hits_q <= '0;
          miss_q <= '0;
          evs_q  <= '0;
          out_q  <= '0;
          st_q   <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall_i) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end
endmodule

`default_nettype wire

@@ hw/rtl/set_assoc_cache_tag_engine.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_engine
// Set-associative tag store with LRU, FIFO or random replacement.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake     | Beat
// in      | input     | valid / stall | sact_pkg::req_t
// out     | output    | valid / stall | sact_pkg::rsp_t
// cfg     | input     | valid / ready | index, data
//
// An access passes through three steps in the back end: set read, update and write,
// result. The single-port set memory keeps read and write apart. A clear has a clear step, then the result.
// Per-set valid flags clear at reset and on clear, so no sweep is needed.
// A two-entry queue keeps taking request beats while a result is stalled, until it is full.
`default_nettype none
`include "assert_macros.svh"

module set_assoc_cache_tag_engine #(
  parameter int NUM_SETS    = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  sact_pkg::req_t       in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output sact_pkg::rsp_t       out_data_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  sact_pkg::cfg_t       cfg_data_i
);
  import sact_pkg::*;

  logic        q_valid, q_pop, busy, seed_wr, cfg_fire;
  req_t        q_data;
  logic [1:0]  policy_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign seed_wr     = cfg_fire && cfg_data_i.index == {1'b0, REG_SEED};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_LRU;
    end else if (cfg_fire && cfg_data_i.index == {1'b0, REG_POLICY}) begin
      policy_q <= cfg_data_i.data[1:0];
    end
  end

  sact_front #(.DEPTH(2)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  sact_back #(
    .NUM_SETS(NUM_SETS), .WAYS(WAYS), .BLOCK_BYTES(BLOCK_BYTES), .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .policy_i(policy_q), .seed_wr_i(seed_wr), .seed_i(cfg_data_i.data[15:0]),
    .busy_o(busy), .out_valid_o, .out_stall_i, .out_data_o
  );

  `ASSERT_CLK(a_pop_has_item, clk_i, rst_ni, q_pop |-> q_valid, "pop from empty queue")
  `ASSERT_CLK(a_out_busy, clk_i, rst_ni, out_valid_o |-> busy, "result while idle")
  `ASSERT_CLK(a_hit_no_evict, clk_i, rst_ni,
    out_valid_o |-> !(out_data_o.hit && out_data_o.evicted), "hit and eviction together")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result moved")
endmodule

`default_nettype wire

@@ dv/tb_set_assoc_cache_tag_engine.sv @@
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_engine
// Self-checking bench for the cache tag engine: a queue-fed driver, a
// monitor and a behavioral tag store predict every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_set_assoc_cache_tag_engine;
  import sact_pkg::*;

  localparam int N_SETS     = 64;
  localparam int N_WAYS     = 4;
  localparam int WDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_t cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  set_assoc_cache_tag_engine i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Behavioral copy of the tag store.
  logic        ln_valid [N_SETS*N_WAYS];
  logic [19:0] ln_tag   [N_SETS*N_WAYS];
  logic [1:0]  rec_rank [N_SETS*N_WAYS];
  logic [1:0]  ins_rank [N_SETS*N_WAYS];
  logic [31:0] hits, misses, evictions;
  logic [15:0] lfsr;
  logic [1:0]  policy;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   send_idle_pct, recv_idle_pct;
  int   hold_cycles;
  int   errors;
  int   wdog;
  int   n_hits_seen, n_evict_seen;

  function automatic void clear_store();
    for (int i = 0; i < N_SETS*N_WAYS; i++) begin
      ln_valid[i] = 1'b0;
      ln_tag[i]   = '0;
      rec_rank[i] = '0;
      ins_rank[i] = '0;
    end
    hits = '0;
    misses = '0;
    evictions = '0;
  endfunction

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Rank 0 is the newest; valid ways newer than the old rank age by one.
  function automatic void make_newest(input bit use_ins, input int base, input int w,
                                      input int old_rank);
    for (int v = 0; v < N_WAYS; v++) begin
      if (v != w && ln_valid[base+v]) begin
        if (use_ins && ins_rank[base+v] < old_rank) ins_rank[base+v]++;
        if (!use_ins && rec_rank[base+v] < old_rank) rec_rank[base+v]++;
      end
    end
    if (use_ins) ins_rank[base+w] = '0;
    else rec_rank[base+w] = '0;
  endfunction

  function automatic int oldest(input bit use_ins, input int base);
    int best;
    best = 0;
    for (int v = 1; v < N_WAYS; v++) begin
      if (use_ins ? (ins_rank[base+v] > ins_rank[base+best])
                  : (rec_rank[base+v] > rec_rank[base+best])) best = v;
    end
    return best;
  endfunction

  function automatic rsp_t lookup_result(input req_t r);
    rsp_t        o;
    int          base, w, old_rec, old_ins;
    logic [19:0] t;
    bit          found, free;
    o = '0;
    w = 0;
    if (r.operation == OP_CLEAR) begin
      clear_store();
    end else begin
      base = int'(r.address[11:6]) * N_WAYS;
      t = r.address[31:12];
      found = 1'b0;
      for (int v = 0; v < N_WAYS; v++) begin
        if (!found && ln_valid[base+v] && ln_tag[base+v] == t) begin
          found = 1'b1;
          w = v;
        end
      end
      if (found) begin
        o.hit = 1'b1;
        hits = bump(hits);
        make_newest(1'b0, base, w, rec_rank[base+w]);
      end else begin
        misses = bump(misses);
        free = 1'b0;
        old_rec = N_WAYS;
        old_ins = N_WAYS;
        for (int v = 0; v < N_WAYS; v++) begin
          if (!free && !ln_valid[base+v]) begin
            free = 1'b1;
            w = v;
          end
        end
        if (!free) begin
          case (policy)
            POL_LRU:  w = oldest(1'b0, base);
            POL_FIFO: w = oldest(1'b1, base);
            POL_RANDOM: begin
              lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_MASK) : (lfsr >> 1);
              w = int'(lfsr[1:0]);
            end
            default:  w = 0;
          endcase
          o.evicted = 1'b1;
          evictions = bump(evictions);
          old_rec = rec_rank[base+w];
          old_ins = ins_rank[base+w];
        end
        make_newest(1'b0, base, w, old_rec);
        make_newest(1'b1, base, w, old_ins);
        ln_valid[base+w] = 1'b1;
        ln_tag[base+w] = t;
      end
    end
    o.way = w[1:0];
    o.hit_count = hits;
    o.miss_count = misses;
    o.eviction_count = evictions;
    return o;
  endfunction

  // Driver: pops the pending queue; a payload is held until accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsps.push_back(lookup_result(in_data_i));
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i <= pending_reqs.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i && pending_reqs.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_reqs.pop_front();
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (e.hit) n_hits_seen++;
          if (e.evicted) n_evict_seen++;
          if (out_data_o.hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, out_data_o.hit);
            errors++;
          end
          if (out_data_o.evicted !== e.evicted) begin
            $error("evicted: expected %0d, got %0d", e.evicted, out_data_o.evicted);
            errors++;
          end
          if (out_data_o.way !== e.way) begin
            $error("way: expected %0d, got %0d", e.way, out_data_o.way);
            errors++;
          end
          if (out_data_o.hit_count !== e.hit_count) begin
            $error("hit_count: expected %0d, got %0d", e.hit_count, out_data_o.hit_count);
            errors++;
          end
          if (out_data_o.miss_count !== e.miss_count) begin
            $error("miss_count: expected %0d, got %0d", e.miss_count,
                   out_data_o.miss_count);
            errors++;
          end
          if (out_data_o.eviction_count !== e.eviction_count) begin
            $error("eviction_count: expected %0d, got %0d", e.eviction_count,
                   out_data_o.eviction_count);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("timeout: %0d results outstanding", expected_rsps.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= '{index: idx, data: value};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == 2'(REG_POLICY)) policy = value[1:0];
    else if (idx == 2'(REG_SEED)) lfsr = (value[15:0] == 16'd0) ? 16'd1 : value[15:0];
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic req_t acc(input logic [31:0] a);
    return '{operation: OP_ACCESS, address: a};
  endfunction

  // Mostly a few hot sets and a small pool of tags, so sets fill and evict.
  function automatic logic [31:0] rand_addr();
    logic [31:0] a;
    a = $urandom();
    if ($urandom_range(9) < 8) begin
      a[11:6] = 6'($urandom_range(3));
      a[31:12] = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 4'($urandom_range(6))};
    end
    return a;
  endfunction

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) == 0) pending_reqs.push_back('{operation: OP_CLEAR,
                                                            address: $urandom()});
      else pending_reqs.push_back(acc(rand_addr()));
    end
  endtask

  initial begin
    errors = 0;
    wdog = 0;
    hold_cycles = 0;
    n_hits_seen = 0;
    n_evict_seen = 0;
    send_idle_pct = 27;
    recv_idle_pct = 58;
    policy = POL_LRU;
    lfsr = 16'd1;
    clear_store();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: address extremes, fills, hits, evictions and a clear.
    pending_reqs.push_back(acc(32'h0000_0000));
    pending_reqs.push_back(acc(32'hFFFF_FFFF));
    pending_reqs.push_back(acc(32'h0000_003F));
    for (int t = 1; t <= 5; t++) pending_reqs.push_back(acc({20'(t), 12'h000}));
    pending_reqs.push_back(acc(32'h0000_2000));
    pending_reqs.push_back(acc(32'h0000_5000));
    pending_reqs.push_back('{operation: OP_CLEAR, address: 32'hFFFF_FFFF});
    pending_reqs.push_back(acc(32'hFFFF_FFFF));
    pending_reqs.push_back(acc(32'hAAAA_AAAA));
    pending_reqs.push_back(acc(32'h5555_5555));
    drain();

    // Long receiver hold while the sender keeps offering beats.
    hold_cycles = 60;
    random_phase(40);
    drain();

    write_reg(2'(REG_POLICY), 32'(POL_FIFO));
    random_phase(200);
    drain();
    send_idle_pct = 58;
    recv_idle_pct = 27;
    write_reg(2'(REG_POLICY), 32'(POL_RANDOM));
    write_reg(2'(REG_SEED), 32'h0000_FFFF);
    random_phase(200);
    drain();
    write_reg(2'(REG_SEED), 32'h0000_0000);
    random_phase(100);
    drain();
    write_reg(2'(REG_POLICY), 32'd3);
    random_phase(100);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(2'(REG_SEED), 32'h0000_0001);
    write_reg(2'(REG_POLICY), 32'(POL_LRU));
    random_phase(250);
    drain();

    $display("Covered all four replacement settings, seed extremes and clears: %0d hits,",
             n_hits_seen);
    $display("%0d evictions checked under sender and receiver back-pressure.",
             n_evict_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ set_assoc_cache_tag_engine.f @@
+incdir+hw/rtl
hw/rtl/sact_pkg.sv
hw/rtl/sact_front.sv
hw/rtl/sact_back.sv
hw/rtl/set_assoc_cache_tag_engine.sv
dv/tb_set_assoc_cache_tag_engine.sv
